/* rtl/lphfi_pkg.sv */
// Shared types and constants for the linear-probe hash find-or-insert unit.
`default_nettype none

package lphfi_pkg;

   localparam int KEY_W       = 64;
   localparam int HASH_W      = 32;
   localparam int INDEX_W     = 10;
   localparam int COUNT_W     = 11;
   localparam int PROBE_W     = 10;
   localparam int MAX_ENTRIES = 1024;

   localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd64;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1;

   localparam logic OP_FIND  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [KEY_W-1:0]  key;
      logic [HASH_W-1:0] hash_value;
   } req_word_type;

   typedef struct packed {
      logic [INDEX_W-1:0] entry_index;
      logic               inserted;
      logic               table_full;
      logic [PROBE_W-1:0] probe_length;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_BUCKET,
      ST_ENTRY,
      ST_RESPOND
   } state_type;

   typedef enum logic [2:0] {
      RES_HOLD,
      RES_CLEAR,
      RES_INSERT,
      RES_FOUND,
      RES_REFUSE
   } res_kind_type;

   typedef struct packed {
      logic         accept;
      logic         sweep;
      logic         entry_read;
      logic         advance;
      logic         insert;
      logic         count_reset;
      logic         load_out;
      res_kind_type result;
   } cmd_type;

   typedef struct packed {
      logic req_clear;
      logic bucket_empty;
      logic key_match;
      logic can_insert;
      logic last_probe;
      logic sweep_last;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

/* rtl/lphfi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lphfi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/lphfi_ctrl.sv */
// Sequencing state machine for sweeps, probes, inserts and result hand-off.
`default_nettype none

module lphfi_ctrl
   import lphfi_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (sts.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = sts.req_clear ? ST_CLEAR : ST_BUCKET;
         end
         ST_CLEAR: begin
            if (sts.sweep_last) state_in = ST_RESPOND;
         end
         ST_BUCKET: begin
            state_in = sts.bucket_empty ? ST_RESPOND : ST_ENTRY;
         end
         ST_ENTRY: begin
            if (sts.key_match || sts.last_probe) state_in = ST_RESPOND;
            else                                  state_in = ST_BUCKET;
         end
         ST_RESPOND: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      cmd.result = RES_HOLD;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_INIT: begin
            cmd.sweep = 1'b1;
         end
         ST_IDLE: begin
            cmd.accept = req_valid;
         end
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               cmd.count_reset = 1'b1;
               cmd.result      = RES_CLEAR;
            end
         end
         ST_BUCKET: begin
            if (sts.bucket_empty) begin
               if (sts.can_insert) begin
                  cmd.insert = 1'b1;
                  cmd.result = RES_INSERT;
               end else begin
                  cmd.result = RES_REFUSE;
               end
            end else begin
               cmd.entry_read = 1'b1;
            end
         end
         ST_ENTRY: begin
            if (sts.key_match) begin
               cmd.result = RES_FOUND;
            end else begin
               cmd.advance = 1'b1;
               if (sts.last_probe) cmd.result = RES_REFUSE;
            end
         end
         ST_RESPOND: begin
            cmd.load_out = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/lphfi_datapath.sv */
// Probe registers, bucket and entry memories, entry counter and result registers.
`default_nettype none

module lphfi_datapath
   import lphfi_pkg::*;
#(
   parameter int LOG2_SIZE  = 10,
   parameter int KEY_WIDTH  = 64,
   parameter int HASH_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire req_word_type       req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_word_type            rsp_data,
   input  wire logic               csr_write_enable,
   input  wire logic [COUNT_W-1:0] csr_write_data,
   input  wire cmd_type            cmd,
   output sts_type                 sts
);

   localparam int TableSize = 1 << LOG2_SIZE;
   localparam int RunW      = LOG2_SIZE + 1;
   localparam int HashBits  = (HASH_WIDTH < HASH_W) ? HASH_WIDTH : HASH_W;
   localparam int EntryW    = HashBits + KEY_WIDTH;

   logic [LOG2_SIZE-1:0] slot_ff, slot_in;
   logic [RunW-1:0]      run_ff, run_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [HashBits-1:0]  hash_ff, hash_in;
   logic [INDEX_W-1:0]   cur_ff, cur_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0]   limit_ff, limit_in;
   logic [LOG2_SIZE-1:0] sweep_ff, sweep_in;
   rsp_word_type         res_ff, res_in;
   rsp_word_type         rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 bkt_wr_en;
   logic [LOG2_SIZE-1:0] bkt_wr_addr;
   logic [INDEX_W-1:0]   bkt_wr_data;
   logic [INDEX_W-1:0]   bkt_rd_data;
   logic [EntryW-1:0]    ent_rd_data;
   logic [31:0]          run_wide;

   // Probe state
   always_comb begin
      slot_in = slot_ff;
      run_in  = run_ff;
      key_in  = key_ff;
      hash_in = hash_ff;
      if (cmd.accept) begin
         slot_in = LOG2_SIZE'(req_data.hash_value[HashBits-1:0]);
         run_in  = '0;
         key_in  = req_data.key[KEY_WIDTH-1:0];
         hash_in = req_data.hash_value[HashBits-1:0];
      end else if (cmd.advance) begin
         slot_in = slot_ff + LOG2_SIZE'(1);
         run_in  = run_ff + RunW'(1);
      end
   end

   assign cur_in   = cmd.entry_read ? bkt_rd_data : cur_ff;
   assign sweep_in = cmd.sweep ? sweep_ff + LOG2_SIZE'(1) : sweep_ff;
   assign limit_in = csr_write_enable ? csr_write_data : limit_ff;

   always_comb begin
      count_in = count_ff;
      if (cmd.count_reset)  count_in = COUNT_RESET;
      else if (cmd.insert)  count_in = count_ff + COUNT_W'(1);
   end

   // Result word
   assign run_wide = 32'(run_in);

   always_comb begin
      res_in = res_ff;
      case (cmd.result)
         RES_HOLD: res_in = res_ff;
         RES_CLEAR: res_in = '0;
         RES_INSERT: begin
            res_in.entry_index  = count_ff[INDEX_W-1:0];
            res_in.inserted     = 1'b1;
            res_in.table_full   = 1'b0;
            res_in.probe_length = run_wide[PROBE_W-1:0];
         end
         RES_FOUND: begin
            res_in.entry_index  = cur_ff;
            res_in.inserted     = 1'b0;
            res_in.table_full   = 1'b0;
            res_in.probe_length = run_wide[PROBE_W-1:0];
         end
         RES_REFUSE: begin
            res_in.entry_index  = '0;
            res_in.inserted     = 1'b0;
            res_in.table_full   = 1'b1;
            res_in.probe_length = run_wide[PROBE_W-1:0];
         end
         default: res_in = res_ff;
      endcase
   end

   // Output register: load a finished word, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         limit_ff     <= LIMIT_RESET;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      run_ff      <= run_in;
      key_ff      <= key_in;
      hash_ff     <= hash_in;
      cur_ff      <= cur_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Bucket store: sweep clears, insert writes the new entry number
   assign bkt_wr_en   = cmd.sweep | cmd.insert;
   assign bkt_wr_addr = cmd.sweep ? sweep_ff : slot_ff;
   assign bkt_wr_data = cmd.sweep ? '0 : count_ff[INDEX_W-1:0];

   lphfi_ram #(
      .WIDTH (INDEX_W),
      .DEPTH (TableSize)
   ) u_bucket_ram (
      .clock   (clock),
      .wr_en   (bkt_wr_en),
      .wr_addr (bkt_wr_addr),
      .wr_data (bkt_wr_data),
      .rd_addr (slot_in),
      .rd_data (bkt_rd_data)
   );

   // Entry store: hash and key side by side, indexed by entry number
   lphfi_ram #(
      .WIDTH (EntryW),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.insert),
      .wr_addr (count_ff[INDEX_W-1:0]),
      .wr_data ({hash_ff, key_ff}),
      .rd_addr (bkt_rd_data),
      .rd_data (ent_rd_data)
   );

   assign sts.req_clear    = (req_data.opcode == OP_CLEAR);
   assign sts.bucket_empty = (bkt_rd_data == '0);
   assign sts.key_match    = (ent_rd_data == {hash_ff, key_ff});
   assign sts.can_insert   = (count_ff < limit_ff) && (count_ff < COUNT_W'(MAX_ENTRIES));
   assign sts.last_probe   = (run_ff == RunW'(TableSize - 1));
   assign sts.sweep_last   = &sweep_ff;
   assign sts.out_free     = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/linear_probe_hash_find_or_insert_unit.sv */
// A find reads the bucket and then the entry for each occupied slot, until an empty slot,
//   a matching key or the last slot of the run; a clear sweeps every bucket.
// Flow: one request at a time, each probe a bucket read then an entry read; the next word
//   is taken in the cycle after the result word is loaded, or later while rsp_stall holds it back.
// Reset: synchronous; a sweep then zeroes every bucket of the bucket memory, with
//   req_stall high throughout. Configuration writes are taken at any time.
`default_nettype none

module linear_probe_hash_find_or_insert_unit
   import lphfi_pkg::*;
#(
   parameter int LOG2_SIZE  = 10,
   parameter int KEY_WIDTH  = 64,
   parameter int HASH_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request words
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_word_type       req_data,
   // result words
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_word_type            rsp_data,
   // entry limit register
   input  wire logic               csr_write_enable,
   input  wire logic [COUNT_W-1:0] csr_write_data
);

   cmd_type cmd;
   sts_type sts;

   // The controller walks sweep, probe, insert and hand-off; it owns the request
   // stall and tells the datapath which registers and memories to update.
   lphfi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the bucket and entry memories, the probe position, the
   // entry counter, the limit register and the output register, which parts the
   // result side from the request side so a finished word may wait while the
   // next word is accepted.
   lphfi_datapath #(
      .LOG2_SIZE  (LOG2_SIZE),
      .KEY_WIDTH  (KEY_WIDTH),
      .HASH_WIDTH (HASH_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

`default_nettype wire

/* rtl/lphfi_checker.sv */
// Port-level assertions for the hash find-or-insert unit, bound to the top level.
`default_nettype none

module lphfi_checker
   import lphfi_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_stall,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_word_type rsp_data
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // reset drops any pending result
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // hold off requests while in reset
   a_reset_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during reset");

   // an appended key always gets a real entry number
   a_insert_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.inserted |-> rsp_data.entry_index != '0)
      else $error("insert returned entry zero");

   // a refusal carries no entry and no insert
   a_refuse_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.table_full |->
         rsp_data.entry_index == '0 && !rsp_data.inserted)
      else $error("refused word carries an entry");

endmodule

bind linear_probe_hash_find_or_insert_unit lphfi_checker u_checker (.*);

`default_nettype wire

/* tb/linear_probe_hash_find_or_insert_unit_tb.sv */
// Self-checking testbench for the linear-probe hash find-or-insert unit.

module linear_probe_hash_find_or_insert_unit_tb;
   import lphfi_pkg::*;

   // The block is built with its default sizes: 2^10 buckets.
   localparam int TABLE_SLOTS  = 1 << 10;
   // Wait a little beyond the longest correct reply at the end.
   localparam int SETTLE_WAIT  = 2100;
   localparam int LONG_HOLD    = 400;

   typedef enum logic [1:0] {
      ROW_WORD,
      ROW_LIMIT
   } row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [COUNT_W-1:0] limit;
      req_word_type       word;
      logic               pinned;
      rsp_word_type       result;
   } script_row_type;

   // Directed opening. Rows with pinned set carry a typed answer; the others are
   // judged by the shadow table below.
   localparam int SCRIPT_LEN = 20;
   localparam script_row_type DIRECTED_WORDS [SCRIPT_LEN] = '{
      // empty table: first key lands in entry 1 at its home bucket
      {ROW_WORD,  11'd0,    OP_FIND,  64'h0, 32'h0,        1'b1, 10'd1, 1'b1, 1'b0, 10'd0},
      // all-ones key and hash: home bucket is the last one
      {ROW_WORD,  11'd0,    OP_FIND,  {64{1'b1}}, 32'hFFFF_FFFF,
                                                           1'b1, 10'd2, 1'b1, 1'b0, 10'd0},
      // repeat of the first key: found, nothing appended
      {ROW_WORD,  11'd0,    OP_FIND,  64'h0, 32'h0,        1'b1, 10'd1, 1'b0, 1'b0, 10'd0},
      // same hash, other key: key compare must fail and step on
      {ROW_WORD,  11'd0,    OP_FIND,  64'h5, 32'h0,        1'b0, 22'd0},
      // same bucket, other stored hash
      {ROW_WORD,  11'd0,    OP_FIND,  64'h0, 32'h400,      1'b0, 22'd0},
      // home bucket is the last one and the run wraps to the front
      {ROW_WORD,  11'd0,    OP_FIND,  64'hA, 32'hFFFF_F3FF, 1'b0, 22'd0},
      // found one slot past home
      {ROW_WORD,  11'd0,    OP_FIND,  64'h5, 32'h0,        1'b0, 22'd0},
      {ROW_WORD,  11'd0,    OP_FIND,  64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555,
                                                           1'b0, 22'd0},
      {ROW_WORD,  11'd0,    OP_FIND,  64'h5555_5555_5555_5555, 32'hAAAA_AAAA,
                                                           1'b0, 22'd0},
      // clear: every result field zero
      {ROW_WORD,  11'd0,    OP_CLEAR, 64'h0, 32'h0,        1'b1, 22'd0},
      // count restarted: entry 1 again
      {ROW_WORD,  11'd0,    OP_FIND,  64'h0, 32'h0,        1'b1, 10'd1, 1'b1, 1'b0, 10'd0},
      // limit reached: count is 2, limit 2
      {ROW_LIMIT, 11'd2,    1'b0, 64'h0, 32'h0,            1'b0, 22'd0},
      {ROW_WORD,  11'd0,    OP_FIND,  64'h77, 32'h77,      1'b1, 10'd0, 1'b0, 1'b1, 10'd0},
      // an existing key is still found at the limit
      {ROW_WORD,  11'd0,    OP_FIND,  64'h0, 32'h0,        1'b1, 10'd1, 1'b0, 1'b0, 10'd0},
      // limit of zero refuses every new key
      {ROW_LIMIT, 11'd0,    1'b0, 64'h0, 32'h0,            1'b0, 22'd0},
      {ROW_WORD,  11'd0,    OP_FIND,  64'h99, 32'h12,      1'b1, 10'd0, 1'b0, 1'b1, 10'd0},
      {ROW_WORD,  11'd0,    OP_FIND,  64'h0, 32'h0,        1'b1, 10'd1, 1'b0, 1'b0, 10'd0},
      // top bit of the register
      {ROW_LIMIT, 11'd1024, 1'b0, 64'h0, 32'h0,            1'b0, 22'd0},
      // clear with junk in the key and hash fields
      {ROW_WORD,  11'd0,    OP_CLEAR, {64{1'b1}}, 32'hFFFF_FFFF, 1'b1, 22'd0},
      {ROW_LIMIT, 11'd64,   1'b0, 64'h0, 32'h0,            1'b0, 22'd0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_word_type       req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_word_type       rsp_data;
   logic               csr_write_enable = 1'b0;
   logic [COUNT_W-1:0] csr_write_data = '0;

   // Typed answer travelling alongside the request word it belongs to.
   logic               pin_valid = 1'b0;
   rsp_word_type       pin_word = '0;

   // Idle rates and the one long receiver hold-off.
   int                 send_idle_pct = 35;
   int                 recv_idle_pct = 64;
   logic               long_hold_req = 1'b0;
   logic               long_hold_done = 1'b0;
   int                 hold_left = 0;

   int                 words_sent = 0;
   int                 fail_count = 0;

   // Shadow of the hash table.
   logic [INDEX_W-1:0] slot_owner [TABLE_SLOTS];
   logic [HASH_W-1:0]  owner_hash [MAX_ENTRIES];
   logic [KEY_W-1:0]   owner_key  [MAX_ENTRIES];
   logic [COUNT_W-1:0] next_entry;
   logic [COUNT_W-1:0] limit_copy;
   rsp_word_type       pending_answers [$];

   // Keys already offered, for repeats and near-misses.
   logic [KEY_W-1:0]   seen_keys   [$];
   logic [HASH_W-1:0]  seen_hashes [$];

   always #5 clock = ~clock;

   linear_probe_hash_find_or_insert_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Walk the shadow table for one request word and update it as the block would.
   function automatic rsp_word_type lookup_or_append(input req_word_type w);
      rsp_word_type       r;
      logic [INDEX_W-1:0] slot;
      logic [INDEX_W-1:0] cur;
      int                 run;
      bit                 hit_empty;
      r = '0;
      if (w.opcode == OP_CLEAR) begin
         foreach (slot_owner[i]) slot_owner[i] = '0;
         next_entry = COUNT_RESET;
         return r;
      end
      slot = w.hash_value[INDEX_W-1:0];
      run = 0;
      hit_empty = 1'b0;
      while (run < TABLE_SLOTS) begin
         cur = slot_owner[slot];
         if (cur == '0) begin
            hit_empty = 1'b1;
            break;
         end
         if (owner_hash[cur] == w.hash_value && owner_key[cur] == w.key) begin
            r.entry_index = cur;
            break;
         end
         run++;
         slot = slot + 1'b1;
      end
      if (r.entry_index == '0) begin
         // append only into an empty bucket, below the limit and below 1024 entries
         if (hit_empty && next_entry < limit_copy && next_entry < MAX_ENTRIES) begin
            slot_owner[slot]       = next_entry[INDEX_W-1:0];
            owner_hash[next_entry] = w.hash_value;
            owner_key[next_entry]  = w.key;
            r.entry_index          = next_entry[INDEX_W-1:0];
            r.inserted             = 1'b1;
            next_entry             = next_entry + 1'b1;
         end else begin
            r.table_full = 1'b1;
         end
      end
      r.probe_length = PROBE_W'(run);
      return r;
   endfunction

   // Predict on every accepted request word, check every accepted result word.
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         foreach (slot_owner[i]) slot_owner[i] = '0;
         next_entry = COUNT_RESET;
         limit_copy = LIMIT_RESET;
         pending_answers.delete();
      end else begin
         if (csr_write_enable) limit_copy = csr_write_data;
         if (req_valid && !req_stall) begin
            want = lookup_or_append(req_data);
            if (pin_valid) want = pin_word;
            pending_answers = {pending_answers, want};
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               $error("result word with nothing outstanding: %h", rsp_data);
               fail_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_data.entry_index !== want.entry_index) begin
                  $error("entry_index: expected %0d, actual %0d",
                         want.entry_index, rsp_data.entry_index);
                  fail_count++;
               end
               if (rsp_data.inserted !== want.inserted) begin
                  $error("inserted: expected %0b, actual %0b",
                         want.inserted, rsp_data.inserted);
                  fail_count++;
               end
               if (rsp_data.table_full !== want.table_full) begin
                  $error("table_full: expected %0b, actual %0b",
                         want.table_full, rsp_data.table_full);
                  fail_count++;
               end
               if (rsp_data.probe_length !== want.probe_length) begin
                  $error("probe_length: expected %0d, actual %0d",
                         want.probe_length, rsp_data.probe_length);
                  fail_count++;
               end
            end
         end
      end
   end

   // Receiver: random stall, plus one long hold-off counted here so the block
   // backs up and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (long_hold_req && !long_hold_done) begin
         long_hold_done <= 1'b1;
         hold_left      <= LONG_HOLD;
         rsp_stall      <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Offer one word and hold it until accepted. Idle mix shifts with progress:
   // receiver-heavy gaps, then sender-heavy, then none at all.
   task automatic send_word(input req_word_type w, input logic pinned,
                            input rsp_word_type answer);
      if (words_sent < 600) begin
         send_idle_pct = 35;
         recv_idle_pct <= 64;
      end else if (words_sent < 1200) begin
         send_idle_pct = 64;
         recv_idle_pct <= 35;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct <= 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      pin_valid <= pinned;
      pin_word  <= answer;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // Drop valid and wait until every outstanding word has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   // Change the entry limit only with the block idle.
   task automatic write_limit(input logic [COUNT_W-1:0] value);
      drain_results();
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_clear();
      req_word_type w;
      w.opcode     = OP_CLEAR;
      w.key        = {$urandom, $urandom};
      w.hash_value = $urandom;
      send_word(w, 1'b0, '0);
   endtask

   // Random words: repeats of known keys, same hash with a new key, same key with
   // the upper hash bits flipped, crowded home buckets for long runs, fresh keys.
   task automatic run_random(input int count, input int clear_pct, input int reuse_pct);
      req_word_type w;
      int           pick;
      int           at;
      for (int n = 0; n < count; n++) begin
         pick         = $urandom_range(99);
         w.opcode     = OP_FIND;
         w.key        = {$urandom, $urandom};
         w.hash_value = $urandom;
         if (pick < clear_pct) begin
            w.opcode = OP_CLEAR;
         end else if (seen_keys.size() != 0) begin
            at = $urandom_range(seen_keys.size() - 1);
            if (pick < reuse_pct) begin
               w.key        = seen_keys[at];
               w.hash_value = seen_hashes[at];
            end else begin
               case ($urandom_range(3))
                  0: w.hash_value = seen_hashes[at];
                  1: begin
                     w.key        = seen_keys[at];
                     w.hash_value = seen_hashes[at] ^ {22'($urandom), 10'd0};
                  end
                  2: w.hash_value[INDEX_W-1:0] = 10'($urandom_range(40, 47));
                  default: ;
               endcase
            end
         end
         if (w.opcode == OP_FIND) begin
            seen_keys   = {seen_keys, w.key};
            seen_hashes = {seen_hashes, w.hash_value};
            if (seen_keys.size() > 200) begin
               void'(seen_keys.pop_front());
               void'(seen_hashes.pop_front());
            end
         end
         send_word(w, 1'b0, '0);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed opening; the reset sweep holds off the first word
      for (int r = 0; r < SCRIPT_LEN; r++) begin
         if (DIRECTED_WORDS[r].kind == ROW_LIMIT)
            write_limit(DIRECTED_WORDS[r].limit);
         else
            send_word(DIRECTED_WORDS[r].word, DIRECTED_WORDS[r].pinned,
                      DIRECTED_WORDS[r].result);
      end

      // reset limit, mixed traffic; in the middle hold off the receiver while
      // words keep coming, then pause the sender until all answers are in
      run_random(150, 2, 45);
      long_hold_req <= 1'b1;
      run_random(30, 2, 45);
      drain_results();
      run_random(120, 2, 45);

      // smallest limit: only existing keys get through
      write_limit(11'd1);
      run_random(60, 2, 45);

      // largest useful limit: fill the table to 1023 entries with long runs
      write_limit(11'd1024);
      send_clear();
      run_random(1150, 0, 10);

      // limit above the entry-number range: the 1024 cap still refuses
      write_limit(11'd2047);
      run_random(40, 0, 50);

      // limit of zero over a full table
      write_limit(11'd0);
      run_random(30, 0, 50);

      // a handful of random limits from a clean table
      for (int p = 0; p < 5; p++) begin
         write_limit(11'($urandom_range(1, 200)));
         send_clear();
         run_random(40, 3, 45);
      end

      drain_results();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (fail_count == 0)
         $display("linear_probe_hash_find_or_insert_unit_tb: PASS");
      else
         $display("linear_probe_hash_find_or_insert_unit_tb: FAIL");
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #200_000_000;
      $display("linear_probe_hash_find_or_insert_unit_tb: FAIL");
      $finish;
   end

endmodule

/* sim.f */
rtl/lphfi_pkg.sv
rtl/lphfi_ram.sv
rtl/lphfi_ctrl.sv
rtl/lphfi_datapath.sv
rtl/linear_probe_hash_find_or_insert_unit.sv
rtl/lphfi_checker.sv
tb/linear_probe_hash_find_or_insert_unit_tb.sv
